// File: rtl/core/lcc_pkg.sv
package lcc_pkg;

    localparam int CONF_W  = 16;
    localparam int X_W     = 12;
    localparam int CLASS_W = 4;
    localparam int TOTAL_W = 16;
    localparam int THR_W   = 10;
    localparam int SPAN_W  = 2 * X_W;

    localparam logic [THR_W-1:0] CONFIRM_RESET = 10'd25;

    localparam logic [CLASS_W-1:0] CLS_BUCKET_EMPTY = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_BUCKET_FULL  = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_TRUCK_EMPTY  = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_TRUCK_FULL   = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    typedef struct packed {
        logic [CLASS_W-1:0] det_class;
        logic [CONF_W-1:0]  confidence;
        logic [X_W-1:0]     left_x;
        logic [X_W-1:0]     right_x;
        logic               frame_last;
    } t_det;

    typedef struct packed {
        logic [TOTAL_W-1:0] trucks_loaded;
        logic [TOTAL_W-1:0] buckets_dumped;
        logic               truck_is_full;
        logic               bucket_is_full;
        logic               truck_overflow;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic take;      // item accepted this cycle
        logic scan_run;  // walk the span buffer
        logic finish;    // close the frame, load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

// File: rtl/core/lcc_det_if.sv
interface lcc_det_if;
    import lcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] det_class;
    logic [CONF_W-1:0]  confidence;
    logic [X_W-1:0]     left_x;
    logic [X_W-1:0]     right_x;
    logic               frame_last;

    modport source (output valid, det_class, confidence, left_x, right_x, frame_last,
                    input ready);
    modport sink   (input valid, det_class, confidence, left_x, right_x, frame_last,
                    output ready);
endinterface

// File: rtl/core/lcc_res_if.sv
interface lcc_res_if;
    import lcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] trucks_loaded;
    logic [TOTAL_W-1:0] buckets_dumped;
    logic               truck_is_full;
    logic               bucket_is_full;
    logic               truck_overflow;

    modport source (output valid, trucks_loaded, buckets_dumped, truck_is_full,
                    bucket_is_full, truck_overflow, input ready);
    modport sink   (input valid, trucks_loaded, buckets_dumped, truck_is_full,
                    bucket_is_full, truck_overflow, output ready);
endinterface

// File: rtl/core/lcc_cfg_if.sv
interface lcc_cfg_if;
    import lcc_pkg::*;

    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/lcc_ctrl.sv
module lcc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_det_valid,
    input  logic          i_det_last,
    input  logic          i_out_ready,
    input  lcc_pkg::t_sts i_sts,
    output logic          o_det_ready,
    output logic          o_out_valid,
    output lcc_pkg::t_cmd o_cmd
);
    import lcc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   take, out_free;

    assign o_det_ready = (r_state == ST_IDLE);
    assign take        = i_det_valid && o_det_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_cmd.take     = take;
    assign o_cmd.scan_run = (r_state == ST_SCAN);
    assign o_cmd.finish   = (r_state == ST_SCAN) && i_sts.scan_done && out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (take && i_det_last) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (o_cmd.finish) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/lcc_dpath.sv
module lcc_dpath #(
    parameter int MAX_TRUCKS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lcc_pkg::t_cmd              i_cmd,
    input  lcc_pkg::t_det              i_det,
    input  logic                       i_cfg_we,
    input  logic [lcc_pkg::THR_W-1:0]  i_cfg_data,
    output lcc_pkg::t_sts              o_sts,
    output lcc_pkg::t_result           o_res
);
    import lcc_pkg::*;

    localparam int CW = $clog2(MAX_TRUCKS + 1);
    localparam int AW = (MAX_TRUCKS > 1) ? $clog2(MAX_TRUCKS) : 1;

    logic [THR_W-1:0]   r_confirm;
    logic               r_tflag, n_tflag;
    logic               r_bflag, n_bflag;
    logic [THR_W-1:0]   r_deb, n_deb;
    logic [TOTAL_W-1:0] r_ttotal, n_ttotal;
    logic [TOTAL_W-1:0] r_btotal, n_btotal;
    logic [CW-1:0]      r_cnt;
    logic               r_ovf;
    logic               r_b_seen, r_b_full;
    logic [CONF_W-1:0]  r_b_conf;
    logic [X_W-1:0]     r_b_left, r_b_right;
    logic [CW-1:0]      r_idx;
    logic               r_rd_vld;
    logic [SPAN_W-1:0]  r_rd_data;
    logic               r_hit;
    t_result            r_res;

    logic [SPAN_W-1:0]  r_span_mem [MAX_TRUCKS];

    logic               is_truck, is_bucket, det_full, buf_room, rd_issue, ov;
    logic [THR_W:0]     deb_next;
    logic [X_W-1:0]     t_left, t_right;

    assign is_truck  = (i_det.det_class == CLS_TRUCK_EMPTY) ||
                       (i_det.det_class == CLS_TRUCK_FULL);
    assign is_bucket = (i_det.det_class == CLS_BUCKET_EMPTY) ||
                       (i_det.det_class == CLS_BUCKET_FULL);
    assign det_full  = (i_det.det_class == CLS_TRUCK_FULL);
    assign buf_room  = (r_cnt < CW'(MAX_TRUCKS));
    assign deb_next  = {1'b0, r_deb} + 1'b1;

    // debounce step on each accepted truck detection
    always_comb begin
        n_deb    = r_deb;
        n_tflag  = r_tflag;
        n_ttotal = r_ttotal;
        if (i_cmd.take && is_truck) begin
            if (det_full != r_tflag) begin
                if (deb_next >= {1'b0, r_confirm}) begin
                    n_deb   = '0;
                    n_tflag = det_full;
                    if (r_tflag) n_ttotal = r_ttotal + 1'b1;
                end else begin
                    n_deb = deb_next[THR_W-1:0];
                end
            end else begin
                n_deb = '0;
            end
        end
    end

    // frame-end bucket decision
    always_comb begin
        n_bflag  = r_bflag;
        n_btotal = r_btotal;
        if (i_cmd.finish && r_b_seen) begin
            if (r_b_full) begin
                if (!r_bflag && !r_hit) n_bflag = 1'b1;
            end else if (r_bflag) begin
                if (r_hit) n_btotal = r_btotal + 1'b1;
                n_bflag = 1'b0;
            end
        end
    end

    assign rd_issue = i_cmd.scan_run && (r_idx < r_cnt);
    assign t_left   = r_rd_data[X_W-1:0];
    assign t_right  = r_rd_data[SPAN_W-1:X_W];
    assign ov       = !((r_b_right < t_left) || (t_right < r_b_left));

    assign o_sts.scan_done = !(r_idx < r_cnt) && !r_rd_vld;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm <= CONFIRM_RESET;
            r_tflag   <= 1'b0;
            r_bflag   <= 1'b0;
            r_deb     <= '0;
            r_ttotal  <= '0;
            r_btotal  <= '0;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_b_seen  <= 1'b0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            if (i_cfg_we) r_confirm <= i_cfg_data;
            r_tflag  <= n_tflag;
            r_bflag  <= n_bflag;
            r_deb    <= n_deb;
            r_ttotal <= n_ttotal;
            r_btotal <= n_btotal;
            if (i_cmd.take) begin
                r_idx <= '0;
                r_hit <= 1'b0;
                if (is_truck) begin
                    if (buf_room) r_cnt <= r_cnt + 1'b1;
                    else          r_ovf <= 1'b1;
                end
                if (is_bucket && (!r_b_seen || i_det.confidence > r_b_conf)) begin
                    r_b_seen <= 1'b1;
                end
            end
            if (i_cmd.scan_run) begin
                r_rd_vld <= rd_issue;
                if (rd_issue) r_idx <= r_idx + 1'b1;
                if (r_rd_vld && ov) r_hit <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_cnt    <= '0;
                r_ovf    <= 1'b0;
                r_b_seen <= 1'b0;
            end
        end
    end

    // payload: best bucket and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_bucket && (!r_b_seen || i_det.confidence > r_b_conf)) begin
            r_b_full  <= (i_det.det_class == CLS_BUCKET_FULL);
            r_b_conf  <= i_det.confidence;
            r_b_left  <= i_det.left_x;
            r_b_right <= i_det.right_x;
        end
        if (i_cmd.finish) begin
            r_res.trucks_loaded  <= r_ttotal;
            r_res.buckets_dumped <= n_btotal;
            r_res.truck_is_full  <= r_tflag;
            r_res.bucket_is_full <= n_bflag;
            r_res.truck_overflow <= r_ovf;
        end
    end

    // span buffer, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_truck && buf_room) begin
            r_span_mem[r_cnt[AW-1:0]] <= {i_det.right_x, i_det.left_x};
        end
        if (rd_issue) begin
            r_rd_data <= r_span_mem[r_idx[AW-1:0]];
        end
    end

    assign o_res = r_res;

endmodule

// File: rtl/core/load_cycle_counter_top.sv
// Load cycle counter. Takes one detection per item and returns one result item
// per frame, on the item that carries frame_last. Truck detections step the
// shared debounce counter as they arrive; their x-spans go to a span buffer of
// MAX_TRUCKS entries, and trucks beyond that are counted for debounce only and
// raise truck_overflow. Bucket detections keep the first highest-confidence
// one. Items without frame_last are accepted back to back while the block
// is idle. Once a frame-end item is accepted, the overlap test walks the span
// buffer through its single registered read port, one entry a cycle,
// compares each entry in the cycle after its read, and closes the frame in
// the cycle after the last compare, or directly when no truck was buffered.
// It then waits only if the previous result has not yet been taken. The
// result sits in an output register, so the block returns to accepting
// detections while that result waits. confirm_frames may be written at any
// time the block is idle and takes effect on the next truck detection.
module load_cycle_counter_top #(
    parameter int MAX_TRUCKS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcc_det_if.sink       i_det,
    lcc_cfg_if.sink       i_cfg,
    lcc_res_if.source     o_res
);
    import lcc_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    t_det    det;
    t_result res;

    // pack the detection channel for the datapath
    assign det.det_class  = i_det.det_class;
    assign det.confidence = i_det.confidence;
    assign det.left_x     = i_det.left_x;
    assign det.right_x    = i_det.right_x;
    assign det.frame_last = i_det.frame_last;

    // the threshold register is always writable
    assign i_cfg.ready = 1'b1;

    lcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_det_valid (i_det.valid),
        .i_det_last  (i_det.frame_last),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_det_ready (i_det.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    lcc_dpath #(
        .MAX_TRUCKS (MAX_TRUCKS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_det      (det),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_sts      (sts),
        .o_res      (res)
    );

    // drive the result channel from the output register
    assign o_res.trucks_loaded  = res.trucks_loaded;
    assign o_res.buckets_dumped = res.buckets_dumped;
    assign o_res.truck_is_full  = res.truck_is_full;
    assign o_res.bucket_is_full = res.bucket_is_full;
    assign o_res.truck_overflow = res.truck_overflow;

endmodule

// File: rtl/core/lcc_checker.sv
module lcc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_det_valid,
    input logic                        i_det_ready,
    input logic                        i_det_last,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [lcc_pkg::TOTAL_W-1:0] i_trucks,
    input logic [lcc_pkg::TOTAL_W-1:0] i_dumps
);
    import lcc_pkg::*;

    // a waiting result holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped before taken");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_trucks) && $stable(i_dumps))
        else $error("result changed while stalled");

    // frame end blocks intake while the span buffer is walked
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_det_valid && i_det_ready && i_det_last |=> !i_det_ready)
        else $error("detection taken during frame-end walk");

    // a new result only appears out of the frame-end walk
    a_res_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_det_ready))
        else $error("result raised outside frame end");

endmodule

bind load_cycle_counter_top lcc_checker u_lcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_det_valid (i_det.valid),
    .i_det_ready (i_det.ready),
    .i_det_last  (i_det.frame_last),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_trucks    (o_res.trucks_loaded),
    .i_dumps     (o_res.buckets_dumped)
);

// File: bench/lcc_count_monitor.sv
`timescale 1ns / 100ps

module lcc_count_monitor #(
    parameter int MAX_TRUCKS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lcc_det_if   i_det,
    lcc_cfg_if   i_cfg,
    lcc_res_if   i_res,
    output int   o_mismatches,
    output int   o_results_due
);
    import lcc_pkg::*;

    typedef struct packed {
        logic              full;
        logic [CONF_W-1:0] conf;
        logic [X_W-1:0]    left_x;
        logic [X_W-1:0]    right_x;
    } t_bucket_pick;

    // Mirror of the block's counting state
    logic [THR_W-1:0]   confirm_thr;
    logic               truck_full_now;
    logic               bucket_full_now;
    logic [THR_W-1:0]   debounce;
    logic [TOTAL_W-1:0] loads_total;
    logic [TOTAL_W-1:0] dumps_total;
    logic [SPAN_W-1:0]  truck_spans [MAX_TRUCKS];
    int                 span_fill;
    logic               pick_seen;
    t_bucket_pick       pick;
    logic               crowded;

    t_result totals_due [$];
    t_det    seen_det;
    t_result got_totals;
    t_result want_totals;

    task automatic report(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_mismatches++;
    endtask

    function automatic logic bucket_over_truck();
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < span_fill; k++) begin
            if (!(pick.right_x < truck_spans[k][X_W-1:0] ||
                  truck_spans[k][SPAN_W-1:X_W] < pick.left_x))
                hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic step_debounce(input logic saw_full);
        logic [THR_W:0] next_count;
        if (saw_full != truck_full_now) begin
            next_count = {1'b0, debounce} + 1'b1;
            if (next_count >= {1'b0, confirm_thr}) begin
                debounce = '0;
                if (truck_full_now)
                    loads_total++;
                truck_full_now = saw_full;
            end else begin
                debounce = next_count[THR_W-1:0];
            end
        end else begin
            debounce = '0;
        end
    endtask

    task automatic track_detection(input t_det d);
        t_result totals;
        if (d.det_class == CLS_TRUCK_EMPTY || d.det_class == CLS_TRUCK_FULL) begin
            step_debounce(d.det_class == CLS_TRUCK_FULL);
            if (span_fill < MAX_TRUCKS) begin
                truck_spans[span_fill] = {d.right_x, d.left_x};
                span_fill++;
            end else begin
                crowded = 1'b1;
            end
        end else if (d.det_class == CLS_BUCKET_EMPTY || d.det_class == CLS_BUCKET_FULL) begin
            // first one wins a tie
            if (!pick_seen || d.confidence > pick.conf) begin
                pick_seen    = 1'b1;
                pick.full    = (d.det_class == CLS_BUCKET_FULL);
                pick.conf    = d.confidence;
                pick.left_x  = d.left_x;
                pick.right_x = d.right_x;
            end
        end

        if (d.frame_last) begin
            if (pick_seen) begin
                if (pick.full) begin
                    if (!bucket_full_now && !bucket_over_truck())
                        bucket_full_now = 1'b1;
                end else if (bucket_full_now) begin
                    if (bucket_over_truck())
                        dumps_total++;
                    bucket_full_now = 1'b0;
                end
            end
            totals.trucks_loaded  = loads_total;
            totals.buckets_dumped = dumps_total;
            totals.truck_is_full  = truck_full_now;
            totals.bucket_is_full = bucket_full_now;
            totals.truck_overflow = crowded;
            totals_due.insert(totals_due.size(), totals);
            span_fill = 0;
            pick_seen = 1'b0;
            pick      = '0;
            crowded   = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            confirm_thr     = CONFIRM_RESET;
            truck_full_now  = 1'b0;
            bucket_full_now = 1'b0;
            debounce        = '0;
            loads_total     = '0;
            dumps_total     = '0;
            span_fill       = 0;
            pick_seen       = 1'b0;
            pick            = '0;
            crowded         = 1'b0;
            totals_due.delete();
            o_mismatches    = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                confirm_thr = i_cfg.data;

            if (i_det.valid && i_det.ready) begin
                seen_det.det_class  = i_det.det_class;
                seen_det.confidence = i_det.confidence;
                seen_det.left_x     = i_det.left_x;
                seen_det.right_x    = i_det.right_x;
                seen_det.frame_last = i_det.frame_last;
                track_detection(seen_det);
            end

            if (i_res.valid && i_res.ready) begin
                got_totals.trucks_loaded  = i_res.trucks_loaded;
                got_totals.buckets_dumped = i_res.buckets_dumped;
                got_totals.truck_is_full  = i_res.truck_is_full;
                got_totals.bucket_is_full = i_res.bucket_is_full;
                got_totals.truck_overflow = i_res.truck_overflow;
                if (totals_due.size() == 0) begin
                    report("result item arrived with no frame end pending");
                end else begin
                    want_totals = totals_due.pop_front();
                    if (got_totals.trucks_loaded !== want_totals.trucks_loaded)
                        report($sformatf("trucks_loaded got %0d want %0d",
                               got_totals.trucks_loaded, want_totals.trucks_loaded));
                    if (got_totals.buckets_dumped !== want_totals.buckets_dumped)
                        report($sformatf("buckets_dumped got %0d want %0d",
                               got_totals.buckets_dumped, want_totals.buckets_dumped));
                    if (got_totals.truck_is_full !== want_totals.truck_is_full)
                        report($sformatf("truck_is_full got %b want %b",
                               got_totals.truck_is_full, want_totals.truck_is_full));
                    if (got_totals.bucket_is_full !== want_totals.bucket_is_full)
                        report($sformatf("bucket_is_full got %b want %b",
                               got_totals.bucket_is_full, want_totals.bucket_is_full));
                    if (got_totals.truck_overflow !== want_totals.truck_overflow)
                        report($sformatf("truck_overflow got %b want %b",
                               got_totals.truck_overflow, want_totals.truck_overflow));
                end
            end
        end
        o_results_due <= totals_due.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lcc_pkg::*;

    localparam int TRUCK_SLOTS   = 64;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 1000000;
    // Frame-end walk over a full span buffer, with margin
    localparam int SETTLE_CYCLES = 2 * TRUCK_SLOTS + 16;
    localparam int LONG_HOLD     = 400;
    localparam int CROWD_EVERY   = 50;

    localparam logic [CLASS_W-1:0] CLS_IGNORED_LO = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_IGNORED_HI = 4'd15;
    localparam logic [CONF_W-1:0]  CONF_MAX       = '1;
    localparam logic [CONF_W-1:0]  CONF_HALF      = 16'h8000;
    localparam logic [X_W-1:0]     X_MAX          = '1;

    // Trucks park in the middle of the picture; full buckets swing clear of it
    localparam int TRUCK_LEFT_LO  = 1040;
    localparam int TRUCK_LEFT_HI  = 2000;
    localparam int TRUCK_RIGHT_LO = 2100;
    localparam int TRUCK_RIGHT_HI = 3050;
    localparam int AWAY_LEFT_HI   = 700;
    localparam int AWAY_RIGHT_LO  = 3200;
    localparam int AWAY_RIGHT_HI  = 3900;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lcc_det_if det_ch ();
    lcc_cfg_if cfg_ch ();
    lcc_res_if res_ch ();

    int mismatches;
    int results_due;

    load_cycle_counter_top #(
        .MAX_TRUCKS(TRUCK_SLOTS)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_det  (det_ch),
        .i_cfg  (cfg_ch),
        .o_res  (res_ch)
    );

    lcc_count_monitor #(
        .MAX_TRUCKS(TRUCK_SLOTS)
    ) monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_det        (det_ch),
        .i_cfg        (cfg_ch),
        .i_res        (res_ch),
        .o_mismatches (mismatches),
        .o_results_due(results_due)
    );

    always #1 clk = ~clk;

    // Watchdog: end a hung run
    int cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("load_cycle_counter_top test failed");
            $finish;
        end
    end

    // Scene the fake camera is showing
    logic             scene_truck_full;
    logic             scene_bucket_full;
    int               scene_hold;
    int               truck_left;
    int               truck_right;
    int               frame_no;
    logic [THR_W-1:0] current_thr;
    int               items_sent;
    int               quiet_run;
    bit               hold_request;
    int               ready_run;

    // Pick the sender's idle gap: mostly none or short, a few long, with
    // occasional runs of back-to-back items.
    function automatic int sender_pause();
        int pick;
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            quiet_run = $urandom_range(20, 80);
            return 0;
        end
        if (pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_det det_item(input logic [CLASS_W-1:0] cls,
                                      input logic [CONF_W-1:0] conf,
                                      input logic [X_W-1:0] lx,
                                      input logic [X_W-1:0] rx,
                                      input logic last);
        t_det d;
        d.det_class  = cls;
        d.confidence = conf;
        d.left_x     = lx;
        d.right_x    = rx;
        d.frame_last = last;
        return d;
    endfunction

    function automatic t_det noise_det();
        return det_item(CLASS_W'($urandom()), CONF_W'($urandom()), X_W'($urandom()),
                        X_W'($urandom()), 1'b0);
    endfunction

    function automatic t_det ignored_det();
        return det_item(CLASS_W'($urandom_range(CLS_IGNORED_LO, CLS_IGNORED_HI)),
                        CONF_W'($urandom()), X_W'($urandom()), X_W'($urandom()), 1'b0);
    endfunction

    // Truck seen where the scene puts it, jittered, with the odd misread class
    function automatic t_det scene_truck();
        logic full;
        full = scene_truck_full ^ ($urandom_range(0, 99) < 2);
        return det_item(full ? CLS_TRUCK_FULL : CLS_TRUCK_EMPTY, CONF_W'($urandom()),
                        X_W'(truck_left + $urandom_range(0, 15) - 8),
                        X_W'(truck_right + $urandom_range(0, 15) - 8), 1'b0);
    endfunction

    // Bucket carrying the planned action: full ones swing clear of the truck,
    // empty ones sit over it
    function automatic t_det scene_bucket();
        int lx;
        int rx;
        if (scene_bucket_full) begin
            if ($urandom_range(0, 1)) begin
                lx = $urandom_range(0, AWAY_LEFT_HI);
                rx = lx + $urandom_range(0, 200);
            end else begin
                lx = $urandom_range(AWAY_RIGHT_LO, AWAY_RIGHT_HI);
                rx = lx + $urandom_range(0, 195);
            end
        end else begin
            lx = $urandom_range(truck_left, truck_right);
            rx = $urandom_range(lx, truck_right);
        end
        return det_item(scene_bucket_full ? CLS_BUCKET_FULL : CLS_BUCKET_EMPTY,
                        CONF_W'($urandom_range(CONF_HALF, CONF_MAX)), X_W'(lx), X_W'(rx),
                        1'b0);
    endfunction

    // Offer one item and hold it until taken. Valid stays high across
    // back-to-back items so it never toggles within one step.
    task automatic send_det(input t_det d);
        int gap;
        gap = sender_pause();
        if (gap > 0) begin
            det_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        det_ch.valid      <= 1'b1;
        det_ch.det_class  <= d.det_class;
        det_ch.confidence <= d.confidence;
        det_ch.left_x     <= d.left_x;
        det_ch.right_x    <= d.right_x;
        det_ch.frame_last <= d.frame_last;
        do @(posedge clk); while (!det_ch.ready);
        items_sent++;
    endtask

    // Drop valid and wait out every frame result still owed
    task automatic wait_all_results();
        det_ch.valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    task automatic write_confirm(input logic [THR_W-1:0] thr);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= thr;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        current_thr = thr;
    endtask

    // Build one frame in random order and send it. Most frames follow the
    // scene; some are pure noise, and every so often one is crowded to near or
    // past the span buffer's size.
    task automatic send_scene_frame();
        t_det frame_q [$];
        t_det d;
        int   pick;
        int   n;
        pick = $urandom_range(0, 99);
        if (frame_no % CROWD_EVERY == 0) begin
            n = $urandom_range(TRUCK_SLOTS - 2, TRUCK_SLOTS + 6);
            for (int k = 0; k < n; k++) begin
                d = scene_truck();
                d.left_x  = X_W'($urandom());
                d.right_x = X_W'($urandom());
                frame_q.insert($urandom_range(0, frame_q.size()), d);
            end
            frame_q.insert($urandom_range(0, frame_q.size()), noise_det());
        end else if (pick < 10) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                frame_q.insert(frame_q.size(), noise_det());
        end else begin
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++)
                frame_q.insert($urandom_range(0, frame_q.size()), scene_truck());
            n = $urandom_range(0, 3);
            if (n > 0) begin
                d = scene_bucket();
                frame_q.insert($urandom_range(0, frame_q.size()), d);
                // weaker distractors, ties included
                for (int k = 1; k < n; k++)
                    frame_q.insert($urandom_range(0, frame_q.size()),
                                   det_item(CLASS_W'($urandom_range(CLS_BUCKET_EMPTY,
                                                                    CLS_BUCKET_FULL)),
                                            CONF_W'($urandom_range(0, d.confidence)),
                                            X_W'($urandom()), X_W'($urandom()), 1'b0));
                if ($urandom_range(0, 99) < 70)
                    scene_bucket_full = !scene_bucket_full;
            end
            if ($urandom_range(0, 99) < 20)
                frame_q.insert($urandom_range(0, frame_q.size()), ignored_det());
        end

        // Close the frame, sometimes on an ignored item
        if (frame_q.size() == 0 || $urandom_range(0, 99) < 10)
            frame_q.insert(frame_q.size(), ignored_det());
        frame_q[frame_q.size() - 1].frame_last = 1'b1;
        foreach (frame_q[k])
            send_det(frame_q[k]);

        // Advance the scene: swap the truck once it has been seen long enough
        frame_no++;
        scene_hold--;
        if (scene_hold <= 0) begin
            scene_truck_full = !scene_truck_full;
            scene_hold  = current_thr / 2 + $urandom_range(4, 12);
            truck_left  = $urandom_range(TRUCK_LEFT_LO, TRUCK_LEFT_HI);
            truck_right = $urandom_range(TRUCK_RIGHT_LO, TRUCK_RIGHT_HI);
        end
    endtask

    task automatic run_scene_phase(input int budget);
        int start;
        start = items_sent;
        while (items_sent - start < budget)
            send_scene_frame();
    endtask

    // Result side: ready at random, with runs of always-ready, some short
    // stalls, and one long hold-off on request.
    initial begin : receiver
        int pick;
        res_ch.ready = 1'b0;
        ready_run    = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (ready_run > 0) begin
                ready_run--;
                res_ch.ready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    ready_run = $urandom_range(20, 80);
                    res_ch.ready <= 1'b1;
                end else if (pick < 6) begin
                    res_ch.ready <= 1'b0;
                    repeat ($urandom_range(8, 40)) @(posedge clk);
                end else begin
                    res_ch.ready <= (pick >= 30);
                end
            end
        end
    end

    initial begin : stimulus
        det_ch.valid      = 1'b0;
        det_ch.det_class  = '0;
        det_ch.confidence = '0;
        det_ch.left_x     = '0;
        det_ch.right_x    = '0;
        det_ch.frame_last = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        hold_request      = 1'b0;
        quiet_run         = 0;
        items_sent        = 0;
        frame_no          = 0;
        current_thr       = CONFIRM_RESET;
        scene_truck_full  = 1'b0;
        scene_bucket_full = 1'b1;
        scene_hold        = 1;
        truck_left        = TRUCK_LEFT_LO;
        truck_right       = TRUCK_RIGHT_LO;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ignored class alone still closes the frame
        send_det(det_item(CLS_IGNORED_HI, CONF_MAX, X_MAX, X_MAX, 1'b1));
        // Full bucket touching a truck: no load
        send_det(det_item(CLS_TRUCK_FULL, '0, '0, X_MAX, 1'b0));
        send_det(det_item(CLS_BUCKET_FULL, '0, '0, '0, 1'b1));
        // Confidence tie, first bucket wins; frame closed by an ignored class
        send_det(det_item(CLS_BUCKET_FULL, CONF_HALF, 12'd100, 12'd200, 1'b0));
        send_det(det_item(CLS_BUCKET_EMPTY, CONF_HALF, 12'd1500, 12'd1600, 1'b0));
        send_det(det_item(CLS_TRUCK_EMPTY, CONF_MAX, 12'd1000, 12'd2000, 1'b0));
        send_det(det_item(CLS_IGNORED_LO, '0, '0, '0, 1'b1));
        // Empty bucket meeting a truck on a single shared pixel: dump
        send_det(det_item(CLS_TRUCK_EMPTY, CONF_HALF, X_MAX, X_MAX, 1'b0));
        send_det(det_item(CLS_BUCKET_EMPTY, CONF_MAX, X_MAX, X_MAX, 1'b1));
        // Reversed bucket edges, tested as given
        send_det(det_item(CLS_BUCKET_FULL, 16'd1, 12'd3000, 12'd1000, 1'b0));
        send_det(det_item(CLS_TRUCK_FULL, 16'd7, 12'd1500, 12'd2000, 1'b1));
        // Stronger empty bucket just past the truck wins: clear, no dump
        send_det(det_item(CLS_TRUCK_FULL, 16'd9, 12'd1500, 12'd2000, 1'b0));
        send_det(det_item(CLS_BUCKET_EMPTY, 16'd100, 12'd2000, 12'd2000, 1'b0));
        send_det(det_item(CLS_BUCKET_EMPTY, 16'd200, 12'd2001, 12'd3000, 1'b1));
        // Frame without a bucket
        send_det(det_item(CLS_TRUCK_EMPTY, 16'h5555, 12'h0AA, 12'hAAA, 1'b1));
        // Bucket alone across the whole width: load
        send_det(det_item(CLS_BUCKET_FULL, CONF_MAX, '0, X_MAX, 1'b1));

        // Default threshold, then the extremes, then moderate settings
        run_scene_phase(400);
        write_confirm('0);
        run_scene_phase(150);
        write_confirm(10'd1);
        run_scene_phase(150);
        write_confirm('1);
        run_scene_phase(100);
        write_confirm(10'd4);
        // Block the result side while detections keep coming
        hold_request = 1'b1;
        run_scene_phase(250);
        write_confirm(THR_W'($urandom_range(2, 40)));
        run_scene_phase(300);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_due == 0) begin
            $display("load_cycle_counter_top test passed");
        end else begin
            $display("load_cycle_counter_top test failed");
        end
        $finish;
    end

endmodule
